// File: src/positional_list_insert_delete_defines.svh
// ----------------------------------------------------------------------------
// positional_list_insert_delete_defines.svh
// Assertion macros used by the positional list top module.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// condition must hold at every edge outside reset
`define PLI_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define PLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Operation codes, status codes and cell control types for the positional list.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned LenW    = 5;

  typedef enum logic [ActionW-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_POS   = 3'd5,
    ACT_READ      = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // broadcast to every cell, plus a slot index
  typedef struct packed {
    logic ins;   // open a hole at slot, later entries move up
    logic del;   // close slot, later entries move down
    logic take;  // result carries the entry at slot
  } cell_cmd_t;

endpackage

// File: src/pli_cell.sv
// ----------------------------------------------------------------------------
// pli_cell
// One list slot: holds, loads, or takes its left or right neighbor.
// ----------------------------------------------------------------------------
module pli_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned INDEX = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  pli_pkg::cell_cmd_t      cmd,
  input  logic [IDX_W-1:0]        slot,
  input  logic [pli_pkg::DataW-1:0] ins_value,
  input  logic [pli_pkg::DataW-1:0] left_i,
  input  logic [pli_pkg::DataW-1:0] right_i,
  output logic [pli_pkg::DataW-1:0] entry_o,
  output logic [pli_pkg::DataW-1:0] sel_o
);
  import pli_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = INDEX[IDX_W-1:0];

  logic [DataW-1:0] entry_r;
  logic [DataW-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (en && cmd.ins) begin
      if (MyIdx > slot) begin
        entry_nxt = left_i;
      end else if (MyIdx == slot) begin
        entry_nxt = ins_value;
      end
    end else if (en && cmd.del) begin
      if (MyIdx >= slot) begin
        entry_nxt = right_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign sel_o   = (MyIdx == slot) ? entry_r : '0;

endmodule

// File: src/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Decodes one operation against the current length: status, cell command,
// target slot and next length.
// ----------------------------------------------------------------------------
module pli_ctrl #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  logic [pli_pkg::ActionW-1:0] action,
  input  logic [pli_pkg::PosW-1:0]    position,
  input  logic [CNT_W-1:0]            count,
  output pli_pkg::status_t            status,
  output pli_pkg::cell_cmd_t          cmd,
  output logic [IDX_W-1:0]            slot,
  output logic [CNT_W-1:0]            count_nxt
);
  import pli_pkg::*;

  localparam int unsigned CMP_W = ((CNT_W > PosW) ? CNT_W : PosW) + 1;

  action_t          act;
  logic [CMP_W-1:0] cnt_e;
  logic [CMP_W-1:0] pos_e;
  logic [CMP_W-1:0] slot_e;
  logic             full;
  logic             empty;

  assign act   = action_t'(action);
  assign cnt_e = CMP_W'(count);
  assign pos_e = CMP_W'(position);
  assign full  = (cnt_e >= CMP_W'(CAPACITY));
  assign empty = (cnt_e == '0);

  always_comb begin
    status    = ST_OK;
    cmd       = '0;
    slot_e    = '0;
    count_nxt = count;
    case (act)
      ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
        if (full) begin
          status = ST_FULL;
        end else if ((act == ACT_INS_POS) &&
                     ((pos_e == '0) || (pos_e > cnt_e + CMP_W'(1)))) begin
          status = ST_BADPOS;
        end else begin
          cmd.ins   = 1'b1;
          count_nxt = count + CNT_W'(1);
          if (act == ACT_INS_BACK) begin
            slot_e = cnt_e;
          end else if (act == ACT_INS_POS) begin
            slot_e = pos_e - CMP_W'(1);
          end
        end
      end
      ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS, ACT_READ: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (((act == ACT_DEL_POS) || (act == ACT_READ)) &&
                     ((pos_e == '0) || (pos_e > cnt_e))) begin
          status = ST_BADPOS;
        end else begin
          cmd.take = 1'b1;
          if (act != ACT_READ) begin
            cmd.del   = 1'b1;
            count_nxt = count - CNT_W'(1);
          end
          if (act == ACT_DEL_BACK) begin
            slot_e = cnt_e - CMP_W'(1);
          end else if ((act == ACT_DEL_POS) || (act == ACT_READ)) begin
            slot_e = pos_e - CMP_W'(1);
          end
        end
      end
      default: begin
        status = ST_BADPOS;
      end
    endcase
  end

  assign slot = slot_e[IDX_W-1:0];

endmodule

// File: src/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Latency: the result beat appears on the cycle after the input beat is taken.
// Throughput: one operation per cycle; every cell shifts or holds in parallel,
// and the output register frees whenever out_ready takes the waiting beat.
// Reset: synchronous active-low rst_n clears the length and the output valid;
// slot contents are not cleared (only slots below the length are ever read).
// ----------------------------------------------------------------------------
`include "positional_list_insert_delete_defines.svh"

module positional_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pli_pkg::ActionW-1:0] in_action,
  input  logic [pli_pkg::PosW-1:0]    in_position,
  input  logic [pli_pkg::DataW-1:0]   in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [pli_pkg::DataW-1:0]   out_result_value,
  output logic [pli_pkg::LenW-1:0]    out_length
);
  import pli_pkg::*;

  // slot index spans 0..CAPACITY-1, length spans 0..CAPACITY
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic             acc;
  status_t          dec_status;
  cell_cmd_t        dec_cmd;
  logic [IDX_W-1:0] dec_slot;
  logic [CNT_W-1:0] dec_count_nxt;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [1:0]       out_status_r;
  logic [DataW-1:0] out_value_r;
  logic [CNT_W-1:0] out_count_r;

  logic [DataW-1:0] link [CAPACITY];   // each cell's stored entry
  logic [DataW-1:0] sel  [CAPACITY];   // entry of the addressed cell, else zero
  logic [DataW-1:0] picked;

  // the output register splits the two sides: a new beat is taken while it is
  // empty or as the waiting result leaves
  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  pli_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .action    (in_action),
    .position  (in_position),
    .count     (count_r),
    .status    (dec_status),
    .cmd       (dec_cmd),
    .slot      (dec_slot),
    .count_nxt (dec_count_nxt)
  );

  // row of cells: cell i feeds its entry to cell i+1 (insert shift) and to
  // cell i-1 (delete shift); the ends see zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] left_w;
    logic [DataW-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = link[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = link[i+1];
    end

    pli_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .en        (acc),
      .cmd       (dec_cmd),
      .slot      (dec_slot),
      .ins_value (in_value),
      .left_i    (left_w),
      .right_i   (right_w),
      .entry_o   (link[i]),
      .sel_o     (sel[i])
    );
  end

  // only one cell matches the slot, so an OR over the row picks its entry
  always_comb begin
    picked = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      picked = picked | sel[k];
    end
  end

  assign count_nxt = acc ? dec_count_nxt : count_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded with the beat
  always_ff @(posedge clk) begin
    if (acc) begin
      out_status_r <= dec_status;
      out_value_r  <= dec_cmd.take ? picked : '0;
      out_count_r  <= dec_count_nxt;
    end
  end

  logic [CNT_W+LenW-1:0] len_ext;
  assign len_ext = {{LenW{1'b0}}, out_count_r};

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_length       = len_ext[LenW-1:0];

  // ---- checks ----
  `PLI_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(CAPACITY),
    "length above capacity")
  `PLI_ASSERT_NEXT(a_ins_grows, clk, rst_n, acc && dec_cmd.ins,
    count_r == $past(count_r) + CNT_W'(1), "insert did not grow the list")
  `PLI_ASSERT_NEXT(a_err_holds, clk, rst_n, acc && (dec_status != ST_OK),
    $stable(count_r), "failed operation changed the length")
  `PLI_ASSERT_NEXT(a_len_tracks, clk, rst_n, acc,
    out_valid && (out_count_r == count_r), "reported length differs from state")

endmodule

// File: sim/pli_list_checker.sv
// ----------------------------------------------------------------------------
// pli_list_checker
// Watches both channels of the positional list. It keeps its own copy of the
// list, works out the reply for every operation beat taken in, and compares
// each reply beat field by field with the oldest reply still owed.
// ----------------------------------------------------------------------------
module pli_list_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [pli_pkg::ActionW-1:0] in_action,
  input  logic [pli_pkg::PosW-1:0]    in_position,
  input  logic [pli_pkg::DataW-1:0]   in_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [1:0]                  out_status,
  input  logic [pli_pkg::DataW-1:0]   out_result_value,
  input  logic [pli_pkg::LenW-1:0]    out_length,
  output int                          replies_seen,
  output int                          fail_count,
  output int                          full_hits,
  output int                          empty_hits,
  output int                          badpos_hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import pli_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [DataW-1:0] value;
    logic [LenW-1:0]  len;
  } list_reply_t;

  logic [DataW-1:0] slots [CAPACITY];
  int unsigned      fill;
  list_reply_t      owed_replies [$];
  list_reply_t      want;
  list_reply_t      got;

  // Apply one operation to the shadow list and return the reply it earns.
  function automatic list_reply_t apply_list_op(logic [ActionW-1:0] act,
                                                logic [PosW-1:0] pos,
                                                logic [DataW-1:0] val);
    list_reply_t r;
    int unsigned p;
    r.status = ST_OK;
    r.value  = '0;
    p = pos;
    if (act <= ACT_INS_POS) begin
      if (fill >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        if (act == ACT_INS_FRONT) p = 1;
        else if (act == ACT_INS_BACK) p = fill + 1;
        if (p < 1 || p > fill + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (int k = fill; k > p - 1; k--) slots[k] = slots[k-1];
          slots[p-1] = val;
          fill++;
        end
      end
    end else if (act <= ACT_READ) begin
      if (fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        if (act == ACT_DEL_FRONT) p = 1;
        else if (act == ACT_DEL_BACK) p = fill;
        if (p < 1 || p > fill) begin
          r.status = ST_BADPOS;
        end else begin
          r.value = slots[p-1];
          if (act != ACT_READ) begin
            for (int k = p - 1; k + 1 < fill; k++) slots[k] = slots[k+1];
            fill--;
          end
        end
      end
    end else begin
      r.status = ST_BADPOS;  // undefined code
    end
    r.len = LenW'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill = 0;
      owed_replies.delete();
      replies_seen <= 0;
      fail_count  = 0;
      full_hits   = 0;
      empty_hits  = 0;
      badpos_hits = 0;
    end else begin
      // reply beats first: a beat leaving now belongs to an earlier operation
      if (out_valid && out_ready) begin
        replies_seen <= replies_seen + 1;
        if (owed_replies.size() == 0) begin
          $error("reply beat with no operation outstanding");
          fail_count++;
        end else begin
          want = owed_replies.pop_front();
          got  = '{status_t'(out_status), out_result_value, out_length};
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $error("result_value: expected %0d, got %0d",
                   $signed(want.value), $signed(out_result_value));
            fail_count++;
          end
          if (got.len !== want.len) begin
            $error("length: expected %0d, got %0d", want.len, out_length);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = apply_list_op(in_action, in_position, in_value);
        owed_replies.push_back(want);
        case (want.status)
          ST_FULL:   full_hits++;
          ST_EMPTY:  empty_hits++;
          ST_BADPOS: badpos_hits++;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sim/positional_list_insert_delete_tb.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_tb
// Drives list operations into the positional list and gives the verdict.
// A directed opening walks the empty, full and bad-position cases; random
// operations follow under four idling patterns on the two channels. All
// prediction and comparison is done by the checker instantiated beside uut.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pli_pkg::*;

  localparam int unsigned CAPACITY       = 16;
  localparam int unsigned PHASE_OPS      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // the one 3-bit code the block does not define
  localparam logic [ActionW-1:0] ACT_UNDEFINED = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [ActionW-1:0] in_action;
  logic [PosW-1:0]    in_position;
  logic [DataW-1:0]   in_value;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [DataW-1:0]   out_result_value;
  logic [LenW-1:0]    out_length;

  int replies_seen, fail_count, full_hits, empty_hits, badpos_hits;
  int ops_sent   = 0;
  int list_len   = 0;    // stimulus-side length, only used to aim positions
  int idle_pct   = 0;    // chance the sender holds off before a beat
  int stall_pct  = 0;    // chance the receiver drops out_ready in a cycle
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  positional_list_insert_delete #(.CAPACITY(CAPACITY)) uut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_action, .in_position, .in_value,
    .out_valid, .out_ready, .out_status, .out_result_value, .out_length
  );

  pli_list_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_action, .in_position, .in_value,
    .out_valid, .out_ready, .out_status, .out_result_value, .out_length,
    .replies_seen, .fail_count, .full_hits, .empty_hits, .badpos_hits
  );

  // Receiver: one draw per cycle, so stalls land on every phase of the work.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: any stretch with no beat on either channel this long is a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Send one operation beat. Random hold-off first, then valid stays high
  // with a steady payload until the edge where in_ready takes it.
  task automatic push_op(logic [ActionW-1:0] act, logic [PosW-1:0] pos,
                         logic [DataW-1:0] val);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ops_sent++;
    // track the length so random positions can be aimed inside the list
    if (act <= ACT_INS_POS) begin
      if (list_len < CAPACITY &&
          (act != ACT_INS_POS || (pos >= 1 && pos <= list_len + 1)))
        list_len++;
    end else if (act <= ACT_READ && act != ACT_READ) begin
      if (list_len > 0 &&
          (act != ACT_DEL_POS || (pos >= 1 && pos <= list_len)))
        list_len--;
    end
  endtask

  // Hold the sender off until every reply owed has been taken.
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_seen != ops_sent) @(posedge clk);
  endtask

  // One random operation. insert_pct sets how hard the list is pushed toward
  // full; most positions land inside the legal range, the rest anywhere.
  task automatic random_op(int insert_pct);
    logic [ActionW-1:0] act;
    logic [PosW-1:0]    pos;
    logic [DataW-1:0]   val;
    int                 roll;
    roll = $urandom_range(99);
    if (roll < 3)
      act = ACT_UNDEFINED;
    else if (roll < insert_pct)
      act = ActionW'($urandom_range(ACT_INS_FRONT, ACT_INS_POS));
    else
      act = ActionW'($urandom_range(ACT_DEL_FRONT, ACT_READ));
    if ($urandom_range(99) < 12)
      pos = PosW'($urandom_range(31));
    else if (act <= ACT_INS_POS)
      pos = PosW'($urandom_range(1, list_len + 1));
    else
      pos = PosW'(list_len == 0 ? 1 : $urandom_range(1, list_len));
    case ($urandom_range(7))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7fff_ffff;
      2:       val = '0;
      3:       val = '1;
      default: val = $urandom;
    endcase
    push_op(act, pos, val);
  endtask

  int phase_idle  [4] = '{0, 84, 0, 36};
  int phase_stall [4] = '{0, 0, 84, 36};
  int insert_pct;

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = ACT_INS_FRONT;
    in_position = '0;
    in_value    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: empty list, extremes, undefined code, full list ---
    push_op(ACT_READ,      5'd1,  32'h1111_1111);  // read on empty
    push_op(ACT_DEL_FRONT, 5'd0,  '0);             // delete on empty, all forms
    push_op(ACT_DEL_BACK,  5'd31, '0);
    push_op(ACT_DEL_POS,   5'd1,  '0);
    push_op(ACT_INS_POS,   5'd0,  32'h2222_2222);  // below the legal range
    push_op(ACT_INS_POS,   5'd1,  32'h8000_0000);  // most negative value
    push_op(ACT_INS_FRONT, 5'd31, 32'h7fff_ffff);  // position ignored
    push_op(ACT_INS_BACK,  5'd0,  '0);
    push_op(ACT_INS_BACK,  5'd17, '1);
    push_op(ACT_READ,      5'd4,  '0);             // last entry
    push_op(ACT_READ,      5'd5,  '0);             // one past the end
    push_op(ACT_UNDEFINED, 5'd31, 32'ha5a5_a5a5);
    // fill to capacity, each insert just past the current tail
    for (int k = 5; k <= CAPACITY; k++) push_op(ACT_INS_POS, PosW'(k), $urandom);
    push_op(ACT_INS_BACK,  5'd17, 32'h3333_3333);  // insert on a full list, position ignored
    push_op(ACT_DEL_POS,   5'd0,  '0);
    push_op(ACT_DEL_POS,   5'd3,  '0);
    push_op(ACT_DEL_POS,   5'd16, '0);             // one past the end now

    // --- random phases, each under its own idling pattern ---
    for (int ph = 0; ph < 4; ph++) begin
      drain_replies();
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      insert_pct = 50;
      for (int n = 0; n < PHASE_OPS; n++) begin
        // swing between filling and emptying so both ends get visited
        if (n % 32 == 0) begin
          case ($urandom_range(2))
            0:       insert_pct = 25;
            1:       insert_pct = 50;
            default: insert_pct = 80;
          endcase
        end
        if (n == PHASE_OPS / 2) drain_replies();
        random_op(insert_pct);
      end
    end

    drain_replies();
    repeat (4) @(posedge clk);  // room for any stray reply beat

    $display("%0d operations over four idling patterns, %0d replies checked",
             ops_sent, replies_seen);
    $display("error replies seen: list full %0d, list empty %0d, bad position %0d",
             full_hits, empty_hits, badpos_hits);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
